// File: sv/otl_pkg.sv
package otl_pkg;

    localparam int POS_W    = 32;
    localparam int VEL_W    = 25;
    localparam int LIM_W    = 10;
    localparam int TAB_W    = 60;
    localparam int WANT_W   = 44;   // error * 1000 with sign
    localparam int RAD_W    = 58;   // a * |err| << 15
    localparam int ROOT_W   = RAD_W / 2;
    localparam int NUM_W    = 26;   // divider numerator
    localparam int DEN_W    = 11;

    localparam logic [DEN_W-1:0] DEN_ACCEL = 11'd1000;
    localparam logic [DEN_W-1:0] DEN_POS   = 11'd2000;
    localparam logic [9:0]       VEL_SCALE = 10'd1000;
    localparam logic [NUM_W-1:0] RND_ACCEL = 26'd500;
    localparam logic [NUM_W-1:0] RND_POS   = 26'd1000;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_ACCEL = 2'd1;
    localparam logic [1:0] REG_DEAD  = 2'd2;

    localparam logic [TAB_W-1:0] SPEED_RESET = 60'd72128031568822336;
    localparam logic [TAB_W-1:0] ACCEL_RESET = 60'd144256063070404736;
    localparam logic [LIM_W-1:0] DEAD_RESET  = 10'd1;

    localparam logic [1:0] LIM_NONE  = 2'd0;
    localparam logic [1:0] LIM_SPEED = 2'd1;
    localparam logic [1:0] LIM_BRAKE = 2'd2;
    localparam logic [1:0] LIM_ACCEL = 2'd3;

    localparam logic signed [POS_W-1:0] HOME_POSE [6] = '{
        32'sd681574, 32'sd0, 32'sd0, -32'sd1647099, 32'sd0, 32'sd3294199
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_START,
        S_WAIT,
        S_CL1,
        S_CL2,
        S_CL3,
        S_PSTART,
        S_PWAIT,
        S_POS
    } otl_state_t;

endpackage

// File: sv/otl_isqrt.sv
module otl_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [otl_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic [otl_pkg::ROOT_W-1:0]  root
);
    import otl_pkg::*;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    // one root bit per cycle from two radicand bits
    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

// File: sv/otl_sdiv.sv
module otl_sdiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [otl_pkg::NUM_W-1:0]  numer,
    input  logic [otl_pkg::DEN_W-1:0]  denom,
    output logic                       busy,
    output logic [otl_pkg::NUM_W-1:0]  quot
);
    import otl_pkg::*;

    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   rem_sh;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, sh_reg[NUM_W-1]};
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            sh_next   = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = 5'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                sh_next  = {sh_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                sh_next  = {sh_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = sh_reg;
endmodule

// File: sv/online_trajectory_limiter_unit.sv
// Channel  Direction  Handshake             Beat contents
// cfg      in         cfg_write             cfg_index, cfg_data
// in       in         in_valid / in_ready   axis_index, target_position
// out      out        out_valid / out_ready axis_echo, command_position,
//                                           command_velocity, limit_code
//
// One item at a time: the bit-serial square root (braking speed) and the
// bit-serial divider for the position step set the time per item; the accel
// step runs in the divider beside the root. An out-of-range axis beat is
// taken and dropped while the unit stays idle.
// Reset loads the home pose and zero velocity into every axis at once.
// The result register holds while out_ready is low; the next item may be
// accepted meanwhile and stalls only at its final write.
module online_trajectory_limiter_unit #(
    parameter int ARM_COUNT    = 2,
    parameter int AXES_PER_ARM = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [otl_pkg::TAB_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [3:0]                        axis_index,
    input  logic signed [otl_pkg::POS_W-1:0]  target_position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [3:0]                        axis_echo,
    output logic signed [otl_pkg::POS_W-1:0]  command_position,
    output logic signed [otl_pkg::VEL_W-1:0]  command_velocity,
    output logic [1:0]                        limit_code
);
    import otl_pkg::*;

    localparam int AXIS_TOTAL = ARM_COUNT * AXES_PER_ARM;
    localparam int IDXW       = (AXIS_TOTAL > 1) ? $clog2(AXIS_TOTAL) : 1;

    otl_state_t state_reg, state_next;

    // configuration
    logic [TAB_W-1:0] speed_reg, accel_reg;
    logic [LIM_W-1:0] dead_reg;

    // per-axis state, one register per entry
    logic signed [POS_W-1:0] pos_reg [AXIS_TOTAL];
    logic signed [VEL_W-1:0] vel_reg [AXIS_TOTAL];
    logic [2:0]              slot_of [AXIS_TOTAL];

    // working registers for the item in flight
    logic [3:0]               idx_reg;
    logic signed [POS_W-1:0]  tgt_reg;
    logic signed [POS_W-1:0]  pcur_reg;
    logic signed [VEL_W-1:0]  vlast_reg;
    logic [LIM_W-1:0]         vraw_reg, araw_reg;
    logic signed [POS_W:0]    err_reg;
    logic [POS_W:0]           mag_reg;
    logic signed [WANT_W-1:0] v_reg;
    logic                     neg_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [14:0]              astep_reg;
    logic [1:0]               code_reg;
    logic                     sneg_reg;

    // result register
    logic                     out_valid_reg;
    logic [3:0]               echo_reg;
    logic signed [POS_W-1:0]  cpos_reg;
    logic signed [VEL_W-1:0]  cvel_reg;
    logic [1:0]               lcode_reg;

    logic [IDXW-1:0] ix;
    logic            in_fire, idx_ok, out_free, write_back;
    logic            unit_start, pos_start;
    logic            sq_busy, dv_busy;
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  dv_numer;
    logic [DEN_W-1:0]  dv_denom;

    logic signed [POS_W:0]    err_c;
    logic [POS_W:0]           mag_c;
    logic signed [WANT_W-1:0] vmax_c, vdec_c, vhi_c, vlo_c;
    logic signed [VEL_W+1:0]  sum_c;
    logic [VEL_W+1:0]         smag_c;
    logic signed [POS_W+1:0]  npos_c;
    logic signed [POS_W-1:0]  nsat_c;
    logic signed [POS_W+1:0]  step_c;

    assign ix       = IDXW'(idx_reg);
    assign in_fire  = in_valid && in_ready;
    assign idx_ok   = (6'(axis_index) < 6'(AXIS_TOTAL));
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire && idx_ok) state_next = S_LOAD;
            S_LOAD:   state_next = S_MUL;
            S_MUL:    state_next = S_START;
            S_START:  state_next = S_WAIT;
            S_WAIT:   if (!sq_busy && !dv_busy) state_next = S_CL1;
            S_CL1:    state_next = S_CL2;
            S_CL2:    state_next = S_CL3;
            S_CL3:    state_next = S_PSTART;
            S_PSTART: state_next = S_PWAIT;
            S_PWAIT:  if (!dv_busy) state_next = S_POS;
            S_POS:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        unit_start = 1'b0;
        pos_start  = 1'b0;
        write_back = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_START:  unit_start = 1'b1;
            S_PSTART: pos_start = 1'b1;
            S_POS:    write_back = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
            accel_reg <= ACCEL_RESET;
            dead_reg  <= DEAD_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SPEED) speed_reg <= cfg_data;
            if (cfg_index == REG_ACCEL) accel_reg <= cfg_data;
            if (cfg_index == REG_DEAD)  dead_reg  <= cfg_data[LIM_W-1:0];
        end
    end

    // per-axis storage with its home pose at reset
    for (genvar g = 0; g < AXIS_TOTAL; g++)
    begin : g_axis
        localparam int SLOT = g % AXES_PER_ARM;
        assign slot_of[g] = 3'(SLOT);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg[g] <= HOME_POSE[SLOT];
                vel_reg[g] <= '0;
            end
            else if (write_back && (ix == IDXW'(g)))
            begin
                pos_reg[g] <= nsat_c;
                vel_reg[g] <= v_reg[VEL_W-1:0];
            end
        end
    end

    // error and dead band
    always_comb
    begin
        err_c = (POS_W+1)'(tgt_reg) - (POS_W+1)'(pos_reg[ix]);
        mag_c = err_c[POS_W] ? (POS_W+1)'(-err_c) : (POS_W+1)'(err_c);
        if (mag_c < (POS_W+1)'(dead_reg))
        begin
            err_c = '0;
            mag_c = '0;
        end
    end

    // clamp limits
    assign vmax_c = $signed({{(WANT_W-LIM_W-14){1'b0}}, vraw_reg, 14'b0});
    assign vdec_c = $signed({{(WANT_W-ROOT_W){1'b0}}, root});
    assign vhi_c  = WANT_W'(vlast_reg) + $signed({{(WANT_W-15){1'b0}}, astep_reg});
    assign vlo_c  = WANT_W'(vlast_reg) - $signed({{(WANT_W-15){1'b0}}, astep_reg});

    // trapezoid step, rounded half away from zero
    assign sum_c  = (VEL_W+2)'($signed(v_reg[VEL_W-1:0])) + (VEL_W+2)'(vlast_reg);
    assign smag_c = sum_c[VEL_W+1] ? (VEL_W+2)'(-sum_c) : (VEL_W+2)'(sum_c);
    assign step_c = sneg_reg ? -$signed((POS_W+2)'(quot)) : $signed((POS_W+2)'(quot));
    assign npos_c = (POS_W+2)'(pcur_reg) + step_c;

    always_comb
    begin
        priority if (npos_c > (POS_W+2)'(34'sh0_7FFF_FFFF))
            nsat_c = 32'sh7FFF_FFFF;
        else if (npos_c < -(POS_W+2)'(34'sh0_8000_0000))
            nsat_c = -32'sh8000_0000;
        else
            nsat_c = npos_c[POS_W-1:0];
    end

    // shared divider: accel step first, then the position step
    always_comb
    begin
        if (pos_start)
        begin
            dv_numer = NUM_W'(smag_c) + RND_POS;
            dv_denom = DEN_POS;
        end
        else
        begin
            dv_numer = NUM_W'({araw_reg, 14'b0}) + RND_ACCEL;
            dv_denom = DEN_ACCEL;
        end
    end

    otl_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .radicand (rad_reg),
        .busy     (sq_busy),
        .root     (root)
    );

    otl_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start || pos_start),
        .numer (dv_numer),
        .denom (dv_denom),
        .busy  (dv_busy),
        .quot  (quot)
    );

    // datapath registers, advanced by state
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg <= axis_index;
                tgt_reg <= target_position;
            end
            S_LOAD:
            begin
                pcur_reg  <= pos_reg[ix];
                vlast_reg <= vel_reg[ix];
                vraw_reg  <= speed_reg[slot_of[ix]*10 +: LIM_W];
                araw_reg  <= accel_reg[slot_of[ix]*10 +: LIM_W];
                err_reg   <= err_c;
                mag_reg   <= mag_c;
            end
            S_MUL:
            begin
                v_reg    <= WANT_W'(err_reg * $signed({1'b0, VEL_SCALE}));
                neg_reg  <= err_reg[POS_W];
                rad_reg  <= {RAD_W'(araw_reg * mag_reg)} << 15;
                code_reg <= LIM_NONE;
            end
            S_CL1:
            begin
                astep_reg <= quot[14:0];
                if (!neg_reg && (v_reg > vmax_c))
                begin
                    v_reg    <= vmax_c;
                    code_reg <= LIM_SPEED;
                end
                else if (neg_reg && (v_reg < -vmax_c))
                begin
                    v_reg    <= -vmax_c;
                    code_reg <= LIM_SPEED;
                end
            end
            S_CL2:
            begin
                if (!neg_reg && (v_reg > vdec_c))
                begin
                    v_reg    <= vdec_c;
                    code_reg <= LIM_BRAKE;
                end
                else if (neg_reg && (v_reg < -vdec_c))
                begin
                    v_reg    <= -vdec_c;
                    code_reg <= LIM_BRAKE;
                end
            end
            S_CL3:
            begin
                if (!neg_reg && (v_reg > vhi_c))
                begin
                    v_reg    <= vhi_c;
                    code_reg <= LIM_ACCEL;
                end
                else if (neg_reg && (v_reg < vlo_c))
                begin
                    v_reg    <= vlo_c;
                    code_reg <= LIM_ACCEL;
                end
            end
            S_PSTART:
            begin
                sneg_reg <= sum_c[VEL_W+1];
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_back)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_back)
        begin
            echo_reg  <= idx_reg;
            cpos_reg  <= nsat_c;
            cvel_reg  <= v_reg[VEL_W-1:0];
            lcode_reg <= code_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign axis_echo        = echo_reg;
    assign command_position = cpos_reg;
    assign command_velocity = cvel_reg;
    assign limit_code       = lcode_reg;
endmodule

// File: test/otl_checker.sv
module otl_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [otl_pkg::TAB_W-1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [3:0]                        axis_index,
    input  logic signed [otl_pkg::POS_W-1:0]  target_position,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [3:0]                        axis_echo,
    input  logic signed [otl_pkg::POS_W-1:0]  command_position,
    input  logic signed [otl_pkg::VEL_W-1:0]  command_velocity,
    input  logic [1:0]                        limit_code,
    output int                                error_count,
    output int                                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import otl_pkg::*;

    localparam int AXIS_TOTAL = 12;

    typedef struct packed {
        logic [3:0]              axis;
        logic signed [POS_W-1:0] pos;
        logic signed [VEL_W-1:0] vel;
        logic [1:0]              code;
    } axis_cmd_t;

    axis_cmd_t     cmd_queue[$];
    logic [59:0]   speed_tab;
    logic [59:0]   accel_tab;
    logic [9:0]    dead_zone;
    longint        axis_pos [AXIS_TOTAL];
    longint        axis_vel [AXIS_TOTAL];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Advance one axis by one tick and return its command.
    function automatic axis_cmd_t tick_axis(logic [3:0] idx, longint target);
        axis_cmd_t r;
        longint unsigned slot, vraw, araw, mag, q;
        longint err, v, vmax, vdec, astep, vlast, pos, sum, npos;
        logic [1:0] code;
        slot = idx % 6;
        vraw = (speed_tab >> (10 * slot)) & 10'h3ff;
        araw = (accel_tab >> (10 * slot)) & 10'h3ff;
        pos = axis_pos[idx];
        vlast = axis_vel[idx];
        code = LIM_NONE;
        err = target - pos;
        mag = (err < 0) ? -err : err;
        if (mag < dead_zone)
        begin
            err = 0;
            mag = 0;
        end
        v = err * 1000;
        vmax = vraw << 14;
        vdec = int_sqrt((araw * 2 * mag) << 14);
        astep = ((araw << 14) + 500) / 1000;
        if (v >= 0)
        begin
            if (v > vmax) begin v = vmax; code = LIM_SPEED; end
            if (v > vdec) begin v = vdec; code = LIM_BRAKE; end
            if (v > vlast + astep) begin v = vlast + astep; code = LIM_ACCEL; end
        end
        else
        begin
            if (v < -vmax) begin v = -vmax; code = LIM_SPEED; end
            if (v < -vdec) begin v = -vdec; code = LIM_BRAKE; end
            if (v < vlast - astep) begin v = vlast - astep; code = LIM_ACCEL; end
        end
        sum = v + vlast;
        q = ((sum < 0) ? -sum : sum) + 1000;
        q = q / 2000;
        npos = pos + ((sum < 0) ? -longint'(q) : longint'(q));
        if (npos > 64'sd2147483647) npos = 64'sd2147483647;
        if (npos < -64'sd2147483648) npos = -64'sd2147483648;
        axis_pos[idx] = npos;
        axis_vel[idx] = v;
        r.axis = idx;
        r.pos = npos[31:0];
        r.vel = v[24:0];
        r.code = code;
        return r;
    endfunction

    assign pending_count = cmd_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        axis_cmd_t e;
        if (!rst_n)
        begin
            speed_tab = SPEED_RESET;
            accel_tab = ACCEL_RESET;
            dead_zone = DEAD_RESET;
            for (int k = 0; k < AXIS_TOTAL; k++)
            begin
                axis_pos[k] = HOME_POSE[k % 6];
                axis_vel[k] = 0;
            end
            cmd_queue.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_SPEED) speed_tab = cfg_data;
                else if (cfg_index == REG_ACCEL) accel_tab = cfg_data;
                else if (cfg_index == REG_DEAD) dead_zone = cfg_data[9:0];
            end
            if (out_valid && out_ready)
            begin
                if (cmd_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat axis %0d", $time, axis_echo);
                    error_count++;
                end
                else
                begin
                    e = cmd_queue.pop_front();
                    if (e.axis !== axis_echo || e.pos !== command_position
                        || e.vel !== command_velocity || e.code !== limit_code)
                    begin
                        $display("%0t: mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $time, e.axis, e.pos, e.vel, e.code, axis_echo,
                                 command_position, command_velocity, limit_code);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready && axis_index < AXIS_TOTAL)
                cmd_queue.push_back(tick_axis(axis_index, longint'(target_position)));
        end
    end
endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import otl_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [TAB_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [3:0]        axis_index;
    logic signed [31:0] target_position;
    logic              out_valid;
    logic              out_ready;
    logic [3:0]        axis_echo;
    logic signed [31:0] command_position;
    logic signed [24:0] command_velocity;
    logic [1:0]        limit_code;
    int                error_count;
    int                pending_count;
    int                send_idle;   // percent of cycles the sender holds off
    int                recv_stall;  // percent of cycles the receiver stalls
    logic signed [31:0] axis_home [12];

    online_trajectory_limiter_unit dut (.*);

    otl_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop; a correct run ends far earlier.
    initial
    begin
        #200ms;
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: stall at random on every falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // Send one beat: optional idle gap, then hold valid until accepted.
    task automatic send_beat(logic [3:0] idx, logic signed [31:0] tgt);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        in_valid = 1'b1;
        axis_index = idx;
        target_position = tgt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Drain all expected beats, then let the block settle before config.
    task automatic drain;
        while (pending_count != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [TAB_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [59:0] rand_table(int mode);
        logic [59:0] t;
        for (int k = 0; k < 6; k++)
            t[10*k +: 10] = (mode == 0) ? 10'($urandom_range(1023))
                          : (mode == 1) ? 10'($urandom_range(1, 64)) : 10'h3ff;
        return t;
    endfunction

    // Pick a target near the axis's home pose with random reach, or full-range noise.
    function automatic logic signed [31:0] rand_target(logic [3:0] idx);
        int r;
        r = $urandom_range(99);
        if (r < 10) return $urandom;
        if (r < 40) return axis_home[idx % 6] + $signed($urandom_range(4000)) - 2000;
        if (r < 80) return axis_home[idx % 6] + $signed($urandom_range(400000)) - 200000;
        return axis_home[idx % 6] + $signed($urandom_range(8000000)) - 4000000;
    endfunction

    task automatic random_phase(int n);
        logic [3:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = ($urandom_range(99) < 4) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(11));
            send_beat(idx, rand_target(idx));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SPEED;
        cfg_data = '0;
        in_valid = 1'b0;
        axis_index = '0;
        target_position = '0;
        out_ready = 1'b1;
        send_idle = 0;
        recv_stall = 0;
        for (int k = 0; k < 12; k++) axis_home[k] = HOME_POSE[k % 6];
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: extremes, dead band edges, out-of-range axes, no idling.
        send_beat(4'd0, 32'sh7fffffff);
        send_beat(4'd1, 32'sh80000000);
        send_beat(4'd3, HOME_POSE[3]);
        send_beat(4'd5, HOME_POSE[5]);
        send_beat(4'd6, HOME_POSE[0] + 1);
        send_beat(4'd2, 32'sd5);
        send_beat(4'd12, 32'sd100);
        send_beat(4'd15, 32'sh7fffffff);
        send_beat(4'd11, 32'sd4000000);
        send_beat(4'd4, -32'sd1);
        for (int k = 0; k < 12; k++) send_beat(4'(k), 32'sd0);
        drain();

        // Zero limits clamp everything to zero, wide dead band.
        write_reg(REG_SPEED, '0);
        write_reg(REG_ACCEL, '0);
        write_reg(REG_DEAD, 10'h3ff);
        send_beat(4'd0, 32'sd500);
        send_beat(4'd7, 32'sd1023);
        send_beat(4'd8, -32'sd2000000);
        drain();

        // Maximum limits, zero dead band.
        write_reg(REG_SPEED, 60'hfffffffffffffff);
        write_reg(REG_ACCEL, 60'hfffffffffffffff);
        write_reg(REG_DEAD, '0);
        send_beat(4'd9, 32'sh7fffffff);
        send_beat(4'd10, 32'sh80000000);
        drain();

        // Random phases, two per idle/stall mix, with fresh settings each.
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle  = (ph % 4 == 1) ? 51 : (ph % 4 == 3) ? 34 : 0;
            recv_stall = (ph % 4 == 2) ? 51 : (ph % 4 == 3) ? 34 : 0;
            write_reg(REG_SPEED, rand_table(ph % 3));
            write_reg(REG_ACCEL, rand_table((ph + 1) % 3));
            write_reg(REG_DEAD, 10'($urandom_range(1023) >> $urandom_range(9)));
            random_phase(90);
            // Hold off until every expected beat has come, then go on.
            while (pending_count != 0) @(negedge clk);
            random_phase(90);
            drain();
        end

        drain();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// File: filelist.f
sv/otl_pkg.sv
sv/otl_isqrt.sv
sv/otl_sdiv.sv
sv/online_trajectory_limiter_unit.sv
test/otl_checker.sv
test/tb_top.sv
